@@ hdl/gbs_pkg.sv @@
// Shared types and constants for the greedy box suppression block.
// Holds the stored box layout and the sequencer state encoding.
// No dependencies.
package gbs_pkg;

  localparam int MaxBoxesDefault = 64;
  localparam logic [15:0] IouThresholdReset = 16'd19661;
  // 1e-6 m^2 expressed in (1/512 m)^2 and scaled by 2^8
  localparam logic [6:0] EpsScaled = 7'd67;

  // one stored box, last field (x) in the lowest bits
  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] score;
    logic [15:0] length;
    logic [15:0] width;
    logic [15:0] y;
    logic [15:0] x;
  } box_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SCAN_END,
    S_EMIT,
    S_TAKE,
    S_SUP_RD,
    S_SUP_OV,
    S_MUL_I,
    S_MUL_A,
    S_UNI,
    S_MUL_L,
    S_MUL_H,
    S_CMP
  } state_t;

endpackage

@@ hdl/greedy_box_suppression.sv @@
// Greedy non-maximum suppression of axis-aligned boxes, top level.
// Holds the box memory, the sequencer and one shared 22x17 multiplier.
// Depends on gbs_pkg.
//
//  channel  | direction | transaction carries
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | one box; tlast closes the set
//  m_axis   | out       | one kept box; tlast on the final one, tuser=overflow
//  cfg      | in        | iou_threshold, Q0.16
//
// Loading accepts one box per cycle. After the closing box the block is busy:
// each selection pass reads every stored box, and each suppression pass reads
// every stored box and runs the IoU test only on boxes still open, all
// paced by the single memory read port and the shared multiplier.
// Reset (rst, synchronous) empties the set and restores the threshold.
// A stalled output holds the sequencer in place; no input is taken until the
// final kept box of the set has been delivered.
module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int MAX_BOXES = MaxBoxesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // center_x, center_y, box_width, box_length, confidence, tag
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // kept_x, kept_y, kept_width, kept_length, kept_score, kept_tag
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // overflowed
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  state_t state, state_next;

  box_t mem [MAX_BOXES];
  box_t rdata;

  logic [CW-1:0] count;
  logic          ovf;
  logic [MAX_BOXES-1:0] done;
  logic [AW-1:0] idx;
  logic          found;
  logic          have_pend;
  box_t          cand;
  logic [AW-1:0] cand_idx;
  box_t          pend;
  logic [15:0]   thr;

  logic [31:0] area_a;
  logic [31:0] areab;
  logic [33:0] inter;
  logic [16:0] ox, oy;
  logic [15:0] b_w, b_l;
  logic [42:0] tterm;
  logic [37:0] plo;
  logic [36:0] phi;

  box_t        out_box;
  logic        out_valid, out_last, out_ovf;

  logic [21:0] ma;
  logic [16:0] mb;
  logic [38:0] prod;

  logic in_acc, out_acc, at_end;
  logic [34:0] uni;
  logic [59:0] lhs, rhs;

  // overlap of two intervals given as doubled centre -/+ extent
  function automatic logic [16:0] ovl(logic [15:0] ac, logic [15:0] ae,
                                      logic [15:0] bc, logic [15:0] be);
    logic signed [18:0] alo, ahi, blo, bhi, lo, hi, d;
    alo = 19'(signed'({ac, 1'b0})) - signed'(19'(ae));
    ahi = 19'(signed'({ac, 1'b0})) + signed'(19'(ae));
    blo = 19'(signed'({bc, 1'b0})) - signed'(19'(be));
    bhi = 19'(signed'({bc, 1'b0})) + signed'(19'(be));
    lo = (alo > blo) ? alo : blo;
    hi = (ahi < bhi) ? ahi : bhi;
    d = hi - lo;
    return (hi > lo) ? d[16:0] : 17'd0;
  endfunction

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign at_end  = (CW'(idx) == count - CW'(1));
  assign cfg_ready = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_box;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_ovf;

  // shared multiplier
  assign prod = 39'(ma) * 39'(mb);

  assign uni = (35'(area_a) << 2) + (35'(areab) << 2) - 35'(inter);
  assign lhs = 60'({inter, 24'd0});
  assign rhs = (60'(phi) << 22) + 60'(plo);

  // box memory: one write port for loading, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && (count < CW'(MAX_BOXES))) begin
      mem[count[AW-1:0]] <= box_t'(s_axis_tdata);
    end
    rdata <= mem[idx];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:     if (in_acc && s_axis_tlast) state_next = S_SCAN_RD;
      S_SCAN_RD:  state_next = S_SCAN_CMP;
      S_SCAN_CMP: state_next = at_end ? S_SCAN_END : S_SCAN_RD;
      S_SCAN_END: begin
        if (have_pend) state_next = S_EMIT;
        else state_next = S_TAKE;
      end
      S_EMIT: begin
        if (out_acc) state_next = found ? S_TAKE : S_LOAD;
      end
      S_TAKE:     state_next = S_SUP_RD;
      S_SUP_RD:   state_next = S_SUP_OV;
      S_SUP_OV: begin
        if (!done[idx]) state_next = S_MUL_I;
        else if (at_end) state_next = S_SCAN_RD;
        else state_next = S_SUP_RD;
      end
      S_MUL_I:    state_next = S_MUL_A;
      S_MUL_A:    state_next = S_UNI;
      S_UNI:      state_next = S_MUL_L;
      S_MUL_L:    state_next = S_MUL_H;
      S_MUL_H:    state_next = S_CMP;
      S_CMP:      state_next = at_end ? S_SCAN_RD : S_SUP_RD;
      default:    state_next = S_LOAD;
    endcase
  end

  // control outputs: input ready and multiplier operand selection
  always_comb begin
    s_axis_tready = 1'b0;
    ma = 22'd0;
    mb = 17'd0;
    unique case (state)
      S_LOAD:  s_axis_tready = 1'b1;
      S_TAKE: begin
        ma = 22'(cand.width);
        mb = 17'(cand.length);
      end
      S_MUL_I: begin
        ma = 22'(ox);
        mb = oy;
      end
      S_MUL_A: begin
        ma = 22'(b_w);
        mb = 17'(b_l);
      end
      S_MUL_L: begin
        ma = tterm[21:0];
        mb = 17'(thr);
      end
      S_MUL_H: begin
        ma = 22'(tterm[42:22]);
        mb = 17'(thr);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      done      <= '0;
      idx       <= '0;
      found     <= 1'b0;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
      thr       <= IouThresholdReset;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) thr <= cfg_data;
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            // drop the box when the store is full, but keep the set mark
            if (count < CW'(MAX_BOXES)) count <= count + CW'(1);
            else ovf <= 1'b1;
            if (s_axis_tlast) begin
              idx       <= '0;
              found     <= 1'b0;
              have_pend <= 1'b0;
            end
          end
        end
        S_SCAN_CMP: begin
          if (!done[idx] && (!found || (rdata.score > cand.score))) found <= 1'b1;
          if (!at_end) idx <= idx + AW'(1);
        end
        S_SCAN_END: begin
          if (have_pend) out_valid <= 1'b1;
        end
        S_EMIT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            if (!found) begin
              // set closed: empty the store for the next one
              count <= '0;
              ovf   <= 1'b0;
              done  <= '0;
            end
          end
        end
        S_TAKE: begin
          have_pend      <= 1'b1;
          done[cand_idx] <= 1'b1;
          idx            <= '0;
        end
        S_SUP_OV: begin
          if (done[idx]) begin
            if (at_end) begin
              idx   <= '0;
              found <= 1'b0;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        S_CMP: begin
          if (lhs >= rhs) done[idx] <= 1'b1;
          if (at_end) begin
            idx   <= '0;
            found <= 1'b0;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_SCAN_CMP: begin
        if (!done[idx] && (!found || (rdata.score > cand.score))) begin
          cand     <= rdata;
          cand_idx <= idx;
        end
      end
      S_SCAN_END: begin
        out_box  <= pend;
        out_last <= !found;
        out_ovf  <= ovf;
      end
      S_TAKE: begin
        pend   <= cand;
        area_a <= prod[31:0];
      end
      S_SUP_OV: begin
        ox  <= ovl(pend.x, pend.width, rdata.x, rdata.width);
        oy  <= ovl(pend.y, pend.length, rdata.y, rdata.length);
        b_w <= rdata.width;
        b_l <= rdata.length;
      end
      S_MUL_I: inter <= prod[33:0];
      S_MUL_A: areab <= prod[31:0];
      S_UNI:   tterm <= {uni, 8'd0} + 43'(EpsScaled);
      S_MUL_L: plo   <= prod[37:0];
      S_MUL_H: phi   <= prod[36:0];
      default: ;
    endcase
  end

  // a result is only offered from the emit state
  a_out_in_emit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (state == S_EMIT))
    else $error("output valid outside emit state");

  // loading and delivery never overlap
  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result is pending");

  // store fill never exceeds its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BOXES))
    else $error("box count beyond capacity");

  // delivering the final kept box reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (out_acc && m_axis_tlast) |=> (s_axis_tready && (count == '0)))
    else $error("set not closed after final kept box");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for greedy_box_suppression: loads box sets, predicts
// the kept boxes with an in-bench greedy suppression model and checks each one.
// Depends on gbs_pkg and the greedy_box_suppression RTL.
module tb_top;
  import gbs_pkg::*;

  localparam int Capacity = 64;
  localparam int StallLimit = 200000;

  typedef struct packed {
    logic        overflowed;
    logic        last_kept;
    logic [95:0] box;
  } kept_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;  // center_x, center_y, box_width, box_length, confidence, tag
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;  // kept_x, kept_y, kept_width, kept_length, kept_score, kept_tag
  logic        m_axis_tlast;
  logic        m_axis_tuser;  // overflowed
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // predictor state
  box_t        set_boxes[Capacity];
  int          set_count;
  bit          set_overflow;
  logic [15:0] threshold;
  kept_t       kept_queue[$];

  int errors;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit recv_hold;

  greedy_box_suppression dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overlap along one axis in 1/512 m, edges doubled
  function automatic longint overlap_1d(logic [15:0] ca, logic [15:0] ea,
                                        logic [15:0] cb, logic [15:0] eb);
    longint alo, ahi, blo, bhi, lo, hi;
    alo = 2 * longint'($signed(ca)) - longint'(ea);
    ahi = 2 * longint'($signed(ca)) + longint'(ea);
    blo = 2 * longint'($signed(cb)) - longint'(eb);
    bhi = 2 * longint'($signed(cb)) + longint'(eb);
    lo = (alo > blo) ? alo : blo;
    hi = (ahi < bhi) ? ahi : bhi;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic bit suppresses(box_t a, box_t b, logic [15:0] thr);
    logic [63:0] inter, area_a, area_b, uni, lhs, rhs;
    inter = 64'(overlap_1d(a.x, a.width, b.x, b.width))
          * 64'(overlap_1d(a.y, a.length, b.y, b.length));
    area_a = 64'd4 * 64'(a.width) * 64'(a.length);
    area_b = 64'd4 * 64'(b.width) * 64'(b.length);
    uni = area_a + area_b - inter;
    lhs = inter << 24;
    rhs = 64'(thr) * ((uni << 8) + 64'(EpsScaled));
    return lhs >= rhs;
  endfunction

  // take one accepted box into the predicted set; on the closing box, rank
  // and suppress, then queue the kept boxes
  task automatic predict_box(box_t b, bit closing);
    int order[Capacity];
    bit dropped[Capacity];
    int k, last_idx;
    kept_t r;
    if (set_count < Capacity) begin
      set_boxes[set_count] = b;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!closing) return;
    for (int i = 0; i < set_count; i++) begin
      k = i;
      while (k > 0 && set_boxes[order[k-1]].score < set_boxes[i].score) begin
        order[k] = order[k-1];
        k--;
      end
      order[k] = i;
      dropped[i] = 1'b0;
    end
    last_idx = -1;
    for (int i = 0; i < set_count; i++) begin
      if (!dropped[i]) begin
        r.box = set_boxes[order[i]];
        r.last_kept = 1'b0;
        r.overflowed = set_overflow;
        kept_queue.insert(kept_queue.size(), r);
        last_idx = kept_queue.size() - 1;
        for (int j = i + 1; j < set_count; j++)
          if (!dropped[j] && suppresses(set_boxes[order[i]], set_boxes[order[j]], threshold))
            dropped[j] = 1'b1;
      end
    end
    kept_queue[last_idx].last_kept = 1'b1;
    set_count = 0;
    set_overflow = 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [95:0] got, logic [95:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // send one box, idling beforehand at the current sender rate; valid stays
  // up after the transaction until the next idle cycle or a drain drops it
  task automatic send_box(box_t b, bit closing);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= closing;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_box(b, closing);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (kept_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    drain();
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    threshold = value;
  endtask

  function automatic box_t random_box(bit clustered);
    box_t b;
    b = box_t'({$urandom, $urandom, $urandom});
    if (clustered) begin
      // near one another so overlaps are frequent
      b.x = 16'($signed($urandom_range(200)) - 100);
      b.y = 16'($signed($urandom_range(200)) - 100);
      b.width  = 16'($urandom_range(400, 20));
      b.length = 16'($urandom_range(400, 20));
    end
    if ($urandom_range(9) == 0) b.score = 16'($urandom_range(3));
    return b;
  endfunction

  task automatic send_set(int n, bit clustered);
    for (int i = 0; i < n; i++) send_box(random_box(clustered), i == n - 1);
  endtask

  task automatic test_directed();
    box_t b;
    // extremes of every field, one set
    b = '{tag: 16'hFFFF, score: 16'hFFFF, length: 16'hFFFF, width: 16'hFFFF,
          y: 16'h7FFF, x: 16'h8000};
    send_box(b, 1'b0);
    b = '{tag: 16'h0000, score: 16'h0000, length: 16'h0000, width: 16'h0000,
          y: 16'h8000, x: 16'h7FFF};
    send_box(b, 1'b0);
    // equal scores keep arrival order, identical boxes overlap fully
    b = '{tag: 16'd1, score: 16'd500, length: 16'd100, width: 16'd100, y: 16'd0, x: 16'd0};
    send_box(b, 1'b0);
    b.tag = 16'd2;
    send_box(b, 1'b0);
    b = '{tag: 16'd3, score: 16'd500, length: 16'd100, width: 16'd100, y: 16'd0, x: 16'd60};
    send_box(b, 1'b1);
    // single-box set
    send_box(random_box(1'b0), 1'b1);
  endtask

  task automatic test_threshold_extremes();
    write_threshold(16'd0);
    send_set(6, 1'b1);
    send_set(3, 1'b0);
    write_threshold(16'hFFFF);
    send_set(8, 1'b1);
    write_threshold(16'd1);
    send_set(5, 1'b1);
    write_threshold(IouThresholdReset);
  endtask

  task automatic test_overflow();
    // 70 boxes: the last six, the closing one among them, are discarded
    send_set(70, 1'b1);
  endtask

  task automatic test_backpressure();
    // hold the output off while the sender keeps offering the next set
    recv_hold = 1'b1;
    fork
      begin
        send_set(40, 1'b1);
        send_set(4, 1'b1);
      end
      begin
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
      end
    join
  endtask

  task automatic test_random(int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(64, 30) : $urandom_range(10, 1);
      send_set(n, $urandom_range(2) != 0);
      sent += n;
      if ($urandom_range(11) == 0)
        write_threshold(16'($urandom_range(40000)));
    end
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int items);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    test_random(items);
  endtask

  // receiver stalls at the current rate, or holds off completely
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each delivered kept box with the oldest prediction
  always @(posedge clk) begin
    kept_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (kept_queue.size() == 0) begin
        report_mismatch("unexpected box", m_axis_tdata, '0);
      end else begin
        want = kept_queue.pop_front();
        if (m_axis_tdata !== want.box) report_mismatch("box", m_axis_tdata, want.box);
        if (m_axis_tlast !== want.last_kept)
          report_mismatch("last_kept", 96'(m_axis_tlast), 96'(want.last_kept));
        if (m_axis_tuser !== want.overflowed)
          report_mismatch("overflowed", 96'(m_axis_tuser), 96'(want.overflowed));
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    set_count = 0;
    set_overflow = 1'b0;
    threshold = IouThresholdReset;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold_extremes();
    test_overflow();
    test_backpressure();
    run_phase(0, 0, 60);
    run_phase(53, 0, 60);
    run_phase(0, 53, 60);
    run_phase(38, 38, 60);
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
